// ===== hw/rtl/dlce_pkg.sv =====
// Shared types and constants for the display line character expander.
package dlce_pkg;

    // Character codes.
    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_CARET   = 8'd94;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] CTRL_BIAS  = 8'd64;

    // Tab stop limits.
    localparam logic [6:0] MAX_TAB = 7'd64;
    localparam logic [6:0] MIN_TAB = 7'd1;

    // Register reset values.
    localparam logic [6:0] TAB_WIDTH_RST  = 7'd8;
    localparam logic [7:0] LINE_WIDTH_RST = 8'd79;

    // Register indexes, taken from paddr[2].
    localparam logic REG_TAB_WIDTH  = 1'b0;
    localparam logic REG_LINE_WIDTH = 1'b1;

    // Kind of result sequence that a byte produces.
    typedef enum logic [1:0] {
        KIND_END   = 2'd0,
        KIND_TAB   = 2'd1,
        KIND_CARET = 2'd2,
        KIND_CHAR  = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_step;
        logic check;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic is_tab;
        logic div_last;
        logic emit_done;
    } dp_stat_t;

endpackage

// ===== hw/rtl/dlce_ctrl.sv =====
// Sequencing state machine for the display line character expander.
module dlce_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  dlce_pkg::dp_stat_t   stat,
    output dlce_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_CHK  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.check    = 1'b0;
        cmd.emit     = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    priority if (stat.skip) begin
                        state_next = ST_IDLE;
                    end else if (stat.is_tab) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                cmd.check  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (stat.emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/dlce_dp.sv =====
// Datapath: registers, line state, column remainder divider and result register.
module dlce_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input payload.
    input  logic [7:0]           in_ch,
    input  logic                 in_line_start,
    input  logic [7:0]           in_line_offset,
    // Configuration writes.
    input  logic                 cfg_we,
    input  logic                 cfg_sel,
    input  logic [31:0]          cfg_wdata,
    output logic [31:0]          cfg_rdata,
    // Controller link.
    input  dlce_pkg::ctrl_cmd_t  cmd,
    output dlce_pkg::dp_stat_t   stat,
    // Result channel.
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_char,
    output logic                 m_has_char,
    output logic                 m_line_end,
    output logic                 m_last
);

    logic [6:0] tab_width_reg;
    logic [7:0] line_width_reg;
    logic [7:0] column_reg;
    logic [7:0] offset_reg;
    logic       stopped_reg;
    logic [7:0] ch_reg;
    logic [7:0] dvd_reg;
    logic [6:0] rem_reg, rem_next;
    logic [2:0] step_reg;
    dlce_pkg::kind_t kind_reg;
    logic [6:0] cnt_reg;
    logic       m_valid_reg;
    logic [7:0] m_char_reg;
    logic       m_has_char_reg;
    logic       m_line_end_reg;
    logic       m_last_reg;

    logic [6:0] tab_eff;
    logic [7:0] trial;
    logic [6:0] diff;
    logic       is_term;
    logic       is_ctrl;
    logic [6:0] len;
    logic [9:0] need;
    logic       over;
    logic       out_free;
    logic [7:0] emit_char;

    // Configuration registers, readback zero-extended.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_width_reg  <= dlce_pkg::TAB_WIDTH_RST;
            line_width_reg <= dlce_pkg::LINE_WIDTH_RST;
        end else if (cfg_we) begin
            unique case (cfg_sel)
                dlce_pkg::REG_TAB_WIDTH:  tab_width_reg  <= cfg_wdata[6:0];
                dlce_pkg::REG_LINE_WIDTH: line_width_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg_rdata = (cfg_sel == dlce_pkg::REG_LINE_WIDTH) ? {24'd0, line_width_reg}
                                                             : {25'd0, tab_width_reg};

    // Tab width clamped to the supported range.
    always_comb begin
        priority if (tab_width_reg < dlce_pkg::MIN_TAB) begin
            tab_eff = dlce_pkg::MIN_TAB;
        end else if (tab_width_reg > dlce_pkg::MAX_TAB) begin
            tab_eff = dlce_pkg::MAX_TAB;
        end else begin
            tab_eff = tab_width_reg;
        end
    end

    // Status used when a request is accepted: the line start is applied first.
    assign stat.skip   = stopped_reg && !in_line_start;
    assign stat.is_tab = (in_ch == dlce_pkg::CH_TAB);

    // Restoring remainder step: one column bit per cycle, high bit first.
    // The remainder stays below the tab width, so seven bits of the difference suffice.
    assign trial = {rem_reg, dvd_reg[7]};
    assign diff  = trial[6:0] - tab_eff;
    assign rem_next = (trial >= {1'b0, tab_eff}) ? diff : trial[6:0];
    assign stat.div_last = (step_reg == 3'd7);

    // Display length of the latched byte and the width check.
    assign is_term = (ch_reg == dlce_pkg::CH_NUL) || (ch_reg == dlce_pkg::CH_NL);
    assign is_ctrl = (ch_reg < dlce_pkg::CTRL_LIMIT);
    always_comb begin
        priority if (ch_reg == dlce_pkg::CH_TAB) begin
            len = tab_eff - rem_reg;
        end else if (is_ctrl) begin
            len = 7'd2;
        end else begin
            len = 7'd1;
        end
    end
    assign need = {2'b00, column_reg} + {3'b000, len} + {2'b00, offset_reg};
    assign over = need > {2'b00, line_width_reg};

    // Line state, divider and sequence registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= 8'd0;
            offset_reg  <= 8'd0;
            stopped_reg <= 1'b1;
        end else begin
            if (cmd.accept && in_line_start) begin
                column_reg  <= 8'd0;
                offset_reg  <= in_line_offset;
                stopped_reg <= 1'b0;
            end
            if (cmd.check) begin
                if (is_term || over) begin
                    stopped_reg <= 1'b1;
                end else begin
                    column_reg <= column_reg + {1'b0, len};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ch_reg   <= in_ch;
            dvd_reg  <= in_line_start ? 8'd0 : column_reg;
            rem_reg  <= 7'd0;
            step_reg <= 3'd0;
        end else if (cmd.div_step) begin
            dvd_reg  <= {dvd_reg[6:0], 1'b0};
            rem_reg  <= rem_next;
            step_reg <= step_reg + 3'd1;
        end
        if (cmd.check) begin
            priority if (is_term || over) begin
                kind_reg <= dlce_pkg::KIND_END;
                cnt_reg  <= 7'd1;
            end else if (ch_reg == dlce_pkg::CH_TAB) begin
                kind_reg <= dlce_pkg::KIND_TAB;
                cnt_reg  <= len;
            end else if (is_ctrl) begin
                kind_reg <= dlce_pkg::KIND_CARET;
                cnt_reg  <= len;
            end else begin
                kind_reg <= dlce_pkg::KIND_CHAR;
                cnt_reg  <= len;
            end
        end else if (cmd.emit && out_free) begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    // Result register: loads while emitting whenever it is empty or being drained.
    assign out_free       = !m_valid_reg || m_ready;
    assign stat.emit_done = out_free && (cnt_reg == 7'd1);

    always_comb begin
        unique case (kind_reg)
            dlce_pkg::KIND_END:   emit_char = 8'd0;
            dlce_pkg::KIND_TAB:   emit_char = dlce_pkg::CH_SPACE;
            dlce_pkg::KIND_CARET: emit_char = (cnt_reg == 7'd2) ? dlce_pkg::CH_CARET
                                                                : ch_reg + dlce_pkg::CTRL_BIAS;
            dlce_pkg::KIND_CHAR:  emit_char = ch_reg;
            default:              emit_char = ch_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit && out_free) begin
            m_char_reg     <= emit_char;
            m_has_char_reg <= (kind_reg != dlce_pkg::KIND_END);
            m_line_end_reg <= (kind_reg == dlce_pkg::KIND_END);
            m_last_reg     <= (cnt_reg == 7'd1);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_char     = m_char_reg;
    assign m_has_char = m_has_char_reg;
    assign m_line_end = m_line_end_reg;
    assign m_last     = m_last_reg;

endmodule

// ===== hw/rtl/display_line_char_expander.sv =====
// Top level of the display line character expander.
//
//   channel | direction | tdata                        | tuser                  | tlast
//   s_      | in        | [7:0] ch, [15:8] line_offset | [0] line_start         | -
//   m_      | out       | [7:0] out_char               | [0] has_char, [1] line_end | last
//   apb     | in        | reg 0 tab_width at 0x0, reg 1 line_width at 0x4
//
// A byte passes an accept state, for a tab the column remainder divider (one bit
// a cycle), a length check state, then one result per cycle while m_tready is high.
// A byte on a stopped line goes no further than its accept state and yields nothing.
// Reset is synchronous on aresetn: tab_width 8, line_width 79, line stopped.
// A stalled result holds in the output register; s_tready stays low until the last
// result of a byte has entered that register.
module display_line_char_expander (
    input  logic        aclk,
    input  logic        aresetn,
    // Input bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] ch, [15:8] line_offset
    input  logic        s_tuser,   // [0] line_start
    // Display results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic [1:0]  m_tuser,   // [0] has_char, [1] line_end
    output logic        m_tlast,
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dlce_pkg::ctrl_cmd_t cmd;
    dlce_pkg::dp_stat_t  stat;
    logic                cfg_we;
    logic                has_char;
    logic                line_end;

    // Register writes complete in the access cycle.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    dlce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dlce_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_ch          (s_tdata[7:0]),
        .in_line_start  (s_tuser),
        .in_line_offset (s_tdata[15:8]),
        .cfg_we         (cfg_we),
        .cfg_sel        (paddr[2]),
        .cfg_wdata      (pwdata),
        .cfg_rdata      (prdata),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_char         (m_tdata),
        .m_has_char     (has_char),
        .m_line_end     (line_end),
        .m_last         (m_tlast)
    );

    assign m_tuser = {line_end, has_char};

endmodule

// ===== hw/rtl/dlce_checker.sv =====
// Port-level checks for the display line character expander, bound to the top level.
module dlce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An end marker always closes the results of its byte.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("end marker without tlast");

    // An end marker carries no character.
    a_end_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata == 8'd0))
        else $error("end marker carries a character");

    // Every result without a character is an end marker.
    a_nochar_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[1])
        else $error("empty result that is not an end marker");

endmodule

bind display_line_char_expander dlce_checker u_dlce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the display line character expander.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // A run with no request accepted on any port for this many cycles has hung.
    // The longest quiet stretch in a correct run is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 30;
    localparam int DRAIN_CYCLES   = 100;
    localparam int ITEMS_PER_SET  = 27;
    localparam int NUM_SETTINGS   = 6;

    // One display result as it leaves the block.
    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       line_end;
        logic       last;
    } disp_result_t;

    // Tracks the expander state and holds the display results still to come.
    class char_expand_scoreboard;
        logic [6:0] tab_w;
        logic [7:0] line_w;
        logic [7:0] column;
        logic [7:0] held_off;
        bit         stopped;
        disp_result_t expected_chars[$];
        int n_active, n_ignored, n_lines, n_checked, n_errors;

        function new();
            tab_w    = dlce_pkg::TAB_WIDTH_RST;
            line_w   = dlce_pkg::LINE_WIDTH_RST;
            column   = '0;
            held_off = '0;
            stopped  = 1'b1;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == dlce_pkg::REG_TAB_WIDTH) begin
                tab_w = val[6:0];
            end else begin
                line_w = val[7:0];
            end
        endfunction

        function void push(logic [7:0] c, logic has, logic fin, logic lst);
            disp_result_t r;
            r = '{out_char: c, has_char: has, line_end: fin, last: lst};
            expected_chars.push_back(r);
        endfunction

        // Works out the display results of one accepted byte.
        function void expand_byte(logic [7:0] ch, logic start, logic [7:0] off);
            int unsigned stop_w, len, i;
            if (start) begin
                column   = '0;
                held_off = off;
                stopped  = 1'b0;
                n_lines++;
            end
            if (stopped) begin
                n_ignored++;
                return;
            end
            n_active++;
            if (ch == dlce_pkg::CH_NUL || ch == dlce_pkg::CH_NL) begin
                stopped = 1'b1;
                push(8'd0, 1'b0, 1'b1, 1'b1);
                return;
            end
            // Tab spacing is clamped to the supported range.
            stop_w = (tab_w < dlce_pkg::MIN_TAB) ? dlce_pkg::MIN_TAB :
                     (tab_w > dlce_pkg::MAX_TAB) ? dlce_pkg::MAX_TAB : tab_w;
            if (ch == dlce_pkg::CH_TAB) begin
                len = stop_w - (column % stop_w);
            end else if (ch < dlce_pkg::CTRL_LIMIT) begin
                len = 2;
            end else begin
                len = 1;
            end
            // A byte that does not fit ends the line without any of its characters.
            if (column + len + held_off > line_w) begin
                stopped = 1'b1;
                push(8'd0, 1'b0, 1'b1, 1'b1);
                return;
            end
            if (ch == dlce_pkg::CH_TAB) begin
                for (i = 0; i < len; i++) begin
                    push(dlce_pkg::CH_SPACE, 1'b1, 1'b0, i + 1 == len);
                end
            end else if (ch < dlce_pkg::CTRL_LIMIT) begin
                push(dlce_pkg::CH_CARET, 1'b1, 1'b0, 1'b0);
                push(ch + dlce_pkg::CTRL_BIAS, 1'b1, 1'b0, 1'b1);
            end else begin
                push(ch, 1'b1, 1'b0, 1'b1);
            end
            column = 8'(column + len);
        endfunction

        task report(string msg);
            n_errors++;
            $display("mismatch: %s", msg);
        endtask

        // Compares one result from the block with the oldest expectation.
        task check_display(disp_result_t got);
            disp_result_t exp_r;
            n_checked++;
            if (expected_chars.size() == 0) begin
                report($sformatf("result %0d arrived with none expected (char %02h)",
                                 n_checked, got.out_char));
                return;
            end
            exp_r = expected_chars.pop_front();
            if (got.out_char !== exp_r.out_char) begin
                report($sformatf("result %0d out_char %02h, want %02h",
                                 n_checked, got.out_char, exp_r.out_char));
            end
            if (got.has_char !== exp_r.has_char) begin
                report($sformatf("result %0d has_char %b, want %b",
                                 n_checked, got.has_char, exp_r.has_char));
            end
            if (got.line_end !== exp_r.line_end) begin
                report($sformatf("result %0d line_end %b, want %b",
                                 n_checked, got.line_end, exp_r.line_end));
            end
            if (got.last !== exp_r.last) begin
                report($sformatf("result %0d last %b, want %b",
                                 n_checked, got.last, exp_r.last));
            end
        endtask

        task check_leftovers();
            if (expected_chars.size() != 0) begin
                report($sformatf("%0d results never arrived", expected_chars.size()));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    char_expand_scoreboard sb = new();
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int n_holds  = 0;
    int quiet_cycles = 0;

    display_line_char_expander u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Check results, note accepted bytes and watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_display('{out_char: m_tdata, has_char: m_tuser[0],
                                   line_end: m_tuser[1], last: m_tlast});
            end
            if (s_tvalid && s_tready) begin
                sb.expand_byte(s_tdata[7:0], s_tuser, s_tdata[15:8]);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result receiver: random stalls, none in no-idle mode, and one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                n_holds++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 8);
            end
        end
    end

    // Offers one byte and returns at the edge where it is accepted.
    task automatic send_byte(logic [7:0] ch, logic start, logic [7:0] off);
        if (!no_idle && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {off, ch};
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // Reads a register back and compares it with the value last written.
    task automatic read_check(logic idx);
        logic [31:0] want;
        want = (idx == dlce_pkg::REG_TAB_WIDTH) ? {25'd0, sb.tab_w} : {24'd0, sb.line_w};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            sb.report($sformatf("register %0d reads %08h, want %08h", idx, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every expected result is back and the block has settled.
    task automatic wait_idle();
        @(posedge aclk);
        while (sb.expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4) begin
            return ($urandom_range(1) != 0) ? dlce_pkg::CH_NL : dlce_pkg::CH_NUL;
        end else if (r < 18) begin
            return dlce_pkg::CH_TAB;
        end else if (r < 32) begin
            return 8'($urandom_range(1, 31));
        end else if (r < 46) begin
            return 8'($urandom_range(128, 255));
        end
        return 8'($urandom_range(32, 127));
    endfunction

    // Random lines of about target bytes in all: a start byte with an offset that mostly
    // fits, then text that ends by a terminator, by overflow, or by a fresh start;
    // now and then stray bytes.
    task automatic random_lines(int target);
        int sent, n, k;
        logic [7:0] c;
        logic [7:0] off;
        sent = 0;
        while (sent < target) begin
            off = ($urandom_range(99) < 80) ? 8'($urandom_range(0, sb.line_w / 2))
                                            : 8'($urandom_range(0, 255));
            send_byte(pick_char(), 1'b1, off);
            sent++;
            n = $urandom_range(0, 40);
            for (k = 0; k < n && sent < target; k++) begin
                c = pick_char();
                send_byte(c, 1'b0, 8'($urandom_range(0, 255)));
                sent++;
                if (c == dlce_pkg::CH_NUL || c == dlce_pkg::CH_NL) begin
                    if ($urandom_range(2) == 0 && sent < target) begin
                        send_byte(pick_char(), 1'b0, 8'($urandom_range(0, 255)));
                        sent++;
                    end
                    break;
                end
                if ($urandom_range(99) < 3) begin
                    break;
                end
            end
        end
    endtask

    initial begin
        int p;
        logic [6:0] tab_val;
        logic [7:0] line_val;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values, then directed bytes at tab width 8 and line width 79.
        read_check(dlce_pkg::REG_TAB_WIDTH);
        read_check(dlce_pkg::REG_LINE_WIDTH);
        send_byte("A", 1'b0, 8'd0);          // stopped after reset, ignored
        send_byte("A", 1'b1, 8'd0);
        send_byte(dlce_pkg::CH_TAB, 1'b0, 8'd0);       // tab from column one
        send_byte(8'd1, 1'b0, 8'd0);         // caret pair
        send_byte(8'd31, 1'b0, 8'd0);
        send_byte(dlce_pkg::CH_SPACE, 1'b0, 8'd0);
        send_byte(8'd127, 1'b0, 8'd0);
        send_byte(8'd128, 1'b0, 8'd0);       // high bytes print as they are
        send_byte(8'd255, 1'b0, 8'd255);
        send_byte(dlce_pkg::CH_NUL, 1'b0, 8'd0);       // NUL ends the line
        send_byte("B", 1'b0, 8'd0);          // ignored until the next start
        send_byte("x", 1'b1, 8'd255);        // offset alone overflows
        send_byte(dlce_pkg::CH_TAB, 1'b1, 8'd71);      // tab fits exactly
        send_byte(dlce_pkg::CH_TAB, 1'b0, 8'd0);       // second tab overflows
        send_byte(8'd5, 1'b1, 8'd78);        // caret pair overflows
        send_byte("z", 1'b1, 8'd78);         // last column
        send_byte(dlce_pkg::CH_NL, 1'b0, 8'd0);
        send_byte(dlce_pkg::CH_NL, 1'b1, 8'd3);        // newline as first byte
        send_byte("Q", 1'b1, 8'd0);
        send_byte(dlce_pkg::CH_TAB, 1'b1, 8'd5);       // restart in mid line
        send_byte(8'd0, 1'b1, 8'd0);
        s_tvalid <= 1'b0;
        wait_idle();

        // Random lines under several register settings, the extremes among them.
        for (p = 0; p < NUM_SETTINGS; p++) begin
            case (p)
                0:       begin tab_val = 7'd0;   line_val = 8'd255; end
                1:       begin tab_val = 7'd127; line_val = 8'd255; end
                2:       begin tab_val = 7'd1;   line_val = 8'd0;   end
                3:       begin tab_val = dlce_pkg::MAX_TAB; line_val = 8'd1; end
                4:       begin tab_val = 7'd3;   line_val = 8'd40;  end
                default: begin
                    tab_val  = 7'($urandom_range(0, 127));
                    line_val = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(dlce_pkg::REG_TAB_WIDTH,
                      {$urandom_range(0, 1) ? 25'h1ffffff : 25'd0, tab_val});
            write_reg(dlce_pkg::REG_LINE_WIDTH, {24'($urandom), line_val});
            read_check(dlce_pkg::REG_TAB_WIDTH);
            read_check(dlce_pkg::REG_LINE_WIDTH);
            no_idle = (p == 4);
            // Widest tabs: stall the receiver so the block backs up its input.
            if (p == 1) begin
                hold_req = 1'b1;
            end
            random_lines(ITEMS_PER_SET);
            s_tvalid <= 1'b0;
            wait_idle();
        end
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.check_leftovers();
        $display("Covered %0d lines, %0d bytes expanded, %0d bytes on stopped lines.",
                 sb.n_lines, sb.n_active, sb.n_ignored);
        $display("Checked %0d results over %0d register settings, %0d long output stalls.",
                 sb.n_checked, NUM_SETTINGS + 1, n_holds);
        if (sb.n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dlce_pkg.sv
hw/rtl/dlce_ctrl.sv
hw/rtl/dlce_dp.sv
hw/rtl/display_line_char_expander.sv
hw/rtl/dlce_checker.sv
dv/testbench.sv
